### src/asst_pkg.sv
// shared constants and types for the alternating-sum segment tree
`default_nettype none

package asst_pkg;

    localparam int NUM_POSITIONS = 1024;
    localparam int TREE_NODES    = 2 * NUM_POSITIONS;
    localparam int NODE_W        = $clog2(TREE_NODES);
    localparam int CNT_W         = NODE_W + 1;
    localparam int POS_W         = 10;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 42;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [SUM_W-1:0] ZERO_SUM = '0;

    typedef logic [NODE_W-1:0] node_addr_t;
    typedef logic [SUM_W-1:0]  node_sum_t;

    typedef struct packed {
        logic       en;
        node_addr_t addr;
        node_sum_t  data;
    } mem_wr_t;

    typedef struct packed {
        logic       en;
        node_addr_t addr;
    } mem_rd_t;

endpackage

`default_nettype wire

### src/asst_node_ram.sv
// node sum store: one write port, one registered read port
`default_nettype none

module asst_node_ram (
    input  wire logic              clk,
    input  wire asst_pkg::mem_wr_t wr,
    input  wire asst_pkg::mem_rd_t rd,
    output asst_pkg::node_sum_t    rd_data
);
    import asst_pkg::*;

    node_sum_t mem [TREE_NODES];
    node_sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/alternating_sum_segment_tree_core.sv
// alternating-sum segment tree: sequencer over the node sum store
//
// channel  direction  handshake              beat
// item     in         start & !busy          opcode, left_index, right_index, new_value
// result   out        done (one cycle)       alternating_sum
//
// after reset every node of the store is swept to zero, one node a cycle, with busy high.
// a set writes the leaf, then does one read-add-write per tree level up to the root.
// a query steps through ST_QL and ST_QH once per tree level (one store read port, two nodes a level),
// then raises done.
// done is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none

module alternating_sum_segment_tree_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       opcode,
    input  wire logic [asst_pkg::POS_W-1:0] left_index,
    input  wire logic [asst_pkg::POS_W-1:0] right_index,
    input  wire logic signed [asst_pkg::VAL_W-1:0] new_value,
    output logic                            done,
    output logic signed [asst_pkg::SUM_W-1:0] alternating_sum
);
    import asst_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SET   = 5'b00100,
        ST_QL    = 5'b01000,
        ST_QH    = 5'b10000
    } state_t;

    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;
    localparam logic [EXT_W-1:0] LAST_POS = EXT_W'(NUM_POSITIONS - 1);
    localparam logic [EXT_W-1:0] NPOS     = EXT_W'(NUM_POSITIONS);

    state_t     state_reg, state_next;
    node_addr_t k_reg, k_next;
    node_addr_t clr_reg, clr_next;
    node_sum_t  cur_reg, cur_next;
    node_sum_t  acc_reg, acc_next;
    node_sum_t  result_reg, result_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic       pend_reg, pend_next;
    logic       neg_reg, neg_next;
    logic       done_reg, done_next;

    mem_wr_t    wr;
    mem_rd_t    rd;
    node_sum_t  rd_data;

    logic [EXT_W-1:0] left_ext, right_ext, right_clamped;
    node_sum_t  leaf_val, parent_sum, acc_add;
    node_addr_t leaf_addr, k_up;
    logic [CNT_W-1:0] hi_dec;

    asst_node_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        left_ext      = EXT_W'(left_index);
        right_ext     = EXT_W'(right_index);
        right_clamped = (right_ext > LAST_POS) ? LAST_POS : right_ext;
        leaf_addr     = NODE_W'(left_ext + NPOS);
        leaf_val      = SUM_W'(new_value);
        if (left_index[0])
        begin
            leaf_val = ZERO_SUM - leaf_val;
        end
        parent_sum = cur_reg + rd_data;
        k_up       = k_reg >> 1;
        acc_add    = pend_reg ? (acc_reg + rd_data) : acc_reg;
        hi_dec     = hi_reg[0] ? (hi_reg - CNT_W'(1)) : hi_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pend_next   = pend_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        wr          = '0;
        rd          = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                wr.data  = ZERO_SUM;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == node_addr_t'(TREE_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_SET)
                    begin
                        if (left_ext < NPOS)
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = leaf_addr;
                            wr.data    = leaf_val;
                            rd.en      = 1'b1;
                            rd.addr    = leaf_addr ^ NODE_W'(1);
                            k_next     = leaf_addr;
                            cur_next   = leaf_val;
                            state_next = ST_SET;
                        end
                    end
                    else
                    begin
                        lo_next    = CNT_W'(left_ext + NPOS);
                        hi_next    = CNT_W'(right_clamped + NPOS + EXT_W'(1));
                        acc_next   = ZERO_SUM;
                        pend_next  = 1'b0;
                        neg_next   = left_index[0];
                        state_next = ST_QL;
                    end
                end
            end
            ST_SET:
            begin
                // sibling is on rd_data, parent goes back to the store
                wr.en    = 1'b1;
                wr.addr  = k_up;
                wr.data  = parent_sum;
                cur_next = parent_sum;
                k_next   = k_up;
                if (k_up == NODE_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd.en   = 1'b1;
                    rd.addr = k_up ^ NODE_W'(1);
                end
            end
            ST_QL:
            begin
                acc_next = acc_add;
                if (lo_reg < hi_reg)
                begin
                    pend_next = lo_reg[0];
                    if (lo_reg[0])
                    begin
                        rd.en   = 1'b1;
                        rd.addr = lo_reg[NODE_W-1:0];
                        lo_next = lo_reg + CNT_W'(1);
                    end
                    state_next = ST_QH;
                end
                else
                begin
                    pend_next   = 1'b0;
                    result_next = neg_reg ? (ZERO_SUM - acc_add) : acc_add;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_QH:
            begin
                acc_next  = acc_add;
                pend_next = hi_reg[0];
                if (hi_reg[0])
                begin
                    rd.en   = 1'b1;
                    rd.addr = hi_dec[NODE_W-1:0];
                end
                lo_next    = lo_reg >> 1;
                hi_next    = hi_dec >> 1;
                state_next = ST_QL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        neg_reg    <= neg_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign alternating_sum = result_reg;

endmodule

`default_nettype wire
